// File: rtl/utf8_stream_decoder_core_assert.svh
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Immediate-consequence property, sampled on clk_i and disabled during reset.
`define U8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle property, sampled on clk_i and disabled during reset.
`define U8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`else

`define U8SD_ASSERT(lbl, prop, msg)
`define U8SD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/u8sd_pkg.sv
// Types, constants and decode functions of the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned MaxResults = 3;

  localparam logic [CpWidth-1:0] ReplChar = 21'h00FFFD;

  // Lead byte masks and patterns for 2, 3 and 4 byte sequences.
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;

  // Byte order mark.
  localparam logic [7:0] BomByte0 = 8'hEF;
  localparam logic [7:0] BomByte1 = 8'hBB;
  localparam logic [7:0] BomByte2 = 8'hBF;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [CpWidth-1:0] cp;
    logic               repl;
  } res_t;

  // Results caused by one accepted request, oldest in entry 0.
  typedef struct packed {
    logic [1:0]                cnt;
    logic                      eos;
    res_t [MaxResults-1:0]     ent;
  } bundle_t;

  // Sequence length from a lead byte, zero if the byte cannot lead.
  function automatic logic [2:0] lead_len(byte_t b);
    logic [2:0] len;
    if (!b[7]) begin
      len = 3'd1;
    end else if ((b & Lead2Mask) == Lead2Pat) begin
      len = 3'd2;
    end else if ((b & Lead3Mask) == Lead3Pat) begin
      len = 3'd3;
    end else if ((b & Lead4Mask) == Lead4Pat) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [CpWidth-1:0] dec1(byte_t a);
    return {13'd0, a};
  endfunction

  function automatic logic [CpWidth-1:0] dec2(byte_t a, byte_t b);
    return {10'd0, a[4:0], b[5:0]};
  endfunction

  function automatic logic [CpWidth-1:0] dec3(byte_t a, byte_t b, byte_t c);
    return {5'd0, a[3:0], b[5:0], c[5:0]};
  endfunction

  function automatic logic [CpWidth-1:0] dec4(byte_t a, byte_t b, byte_t c, byte_t d);
    return {a[2:0], b[5:0], c[5:0], d[5:0]};
  endfunction

  function automatic res_t mk_res(logic [CpWidth-1:0] cp, logic repl);
    res_t r;
    r.cp   = cp;
    r.repl = repl;
    return r;
  endfunction

  // A lone byte at the string end: plain ASCII or a substitute.
  function automatic res_t tail_one(byte_t y);
    res_t r;
    if (lead_len(y) == 3'd1) begin
      r = mk_res(dec1(y), 1'b0);
    end else begin
      r = mk_res(ReplChar, 1'b1);
    end
    return r;
  endfunction

endpackage

// File: rtl/u8sd_parse.sv
// Pending-sequence state and single-pass parse of one byte into up to three results.
`include "utf8_stream_decoder_core_assert.svh"

module u8sd_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  u8sd_pkg::byte_t  data_byte_i,
  input  logic             string_end_i,
  input  logic             skip_bom_i,
  output u8sd_pkg::bundle_t bundle_o
);
  import u8sd_pkg::*;

  byte_t      pend_q [3];
  logic [1:0] count_q, count_d;
  logic       start_q, start_d;
  logic       buf_en;
  logic       consumed;
  logic       is_bom;
  logic [2:0] len0, lenb, lenx;
  logic [CpWidth-1:0] full_cp;

  always_comb begin
    bundle_o = '0;
    buf_en   = 1'b0;
    consumed = 1'b0;
    len0     = lead_len(pend_q[0]);
    lenb     = lead_len(data_byte_i);
    lenx     = lead_len(pend_q[1]);
    is_bom   = (count_q == 2'd2) && start_q && skip_bom_i && (pend_q[0] == BomByte0)
               && (pend_q[1] == BomByte1) && (data_byte_i == BomByte2);

    unique case (count_q)
      2'd1:    full_cp = dec2(pend_q[0], data_byte_i);
      2'd2:    full_cp = dec3(pend_q[0], pend_q[1], data_byte_i);
      default: full_cp = dec4(pend_q[0], pend_q[1], pend_q[2], data_byte_i);
    endcase

    if (count_q == 2'd0) begin
      if (lenb == 3'd0) begin
        consumed        = 1'b1;
        bundle_o.cnt    = 2'd1;
        bundle_o.ent[0] = mk_res(ReplChar, 1'b1);
      end else if (lenb == 3'd1) begin
        consumed        = 1'b1;
        bundle_o.cnt    = 2'd1;
        bundle_o.ent[0] = mk_res(dec1(data_byte_i), 1'b0);
      end else if (string_end_i) begin
        consumed        = 1'b1;
        bundle_o.cnt    = 2'd1;
        bundle_o.ent[0] = mk_res(ReplChar, 1'b1);
      end else begin
        buf_en = 1'b1;
      end
    end else if (len0 == 3'(count_q) + 3'd1) begin
      // The new byte completes the buffered sequence.
      consumed = 1'b1;
      if (!is_bom) begin
        bundle_o.cnt    = 2'd1;
        bundle_o.ent[0] = mk_res(full_cp, 1'b0);
      end
    end else if (string_end_i) begin
      // Cut sequence: substitute the lead, then parse the rest as leads.
      consumed        = 1'b1;
      bundle_o.ent[0] = mk_res(ReplChar, 1'b1);
      if (count_q == 2'd1) begin
        bundle_o.cnt    = 2'd2;
        bundle_o.ent[1] = tail_one(data_byte_i);
      end else if (lenx == 3'd2) begin
        bundle_o.cnt    = 2'd2;
        bundle_o.ent[1] = mk_res(dec2(pend_q[1], data_byte_i), 1'b0);
      end else if (lenx == 3'd1) begin
        bundle_o.cnt    = 2'd3;
        bundle_o.ent[1] = mk_res(dec1(pend_q[1]), 1'b0);
        bundle_o.ent[2] = tail_one(data_byte_i);
      end else begin
        bundle_o.cnt    = 2'd3;
        bundle_o.ent[1] = mk_res(ReplChar, 1'b1);
        bundle_o.ent[2] = tail_one(data_byte_i);
      end
    end else begin
      buf_en = 1'b1;
    end
    bundle_o.eos = string_end_i;

    count_d = count_q;
    start_d = start_q;
    if (string_end_i) begin
      count_d = 2'd0;
      start_d = 1'b1;
    end else if (consumed) begin
      count_d = 2'd0;
      start_d = 1'b0;
    end else if (buf_en) begin
      count_d = count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      start_q <= 1'b1;
    end else if (accept_i) begin
      count_q <= count_d;
      start_q <= start_d;
    end
  end

  // Pending bytes are appended in place and never shifted.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (accept_i && buf_en && !string_end_i && (count_q == 2'(k))) begin
        pend_q[k] <= data_byte_i;
      end
    end
  end

  `U8SD_ASSERT(a_pend_short, count_q != 2'd0 |-> lead_len(pend_q[0]) > 3'(count_q), "buffered sequence already complete")
  `U8SD_ASSERT_NEXT(a_end_clears, accept_i && string_end_i, count_q == 2'd0 && start_q, "string end did not clear state")

endmodule

// File: rtl/u8sd_burst.sv
// Result register for one request's results, sent one per cycle while output is ready.
`include "utf8_stream_decoder_core_assert.svh"

module u8sd_burst (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  u8sd_pkg::bundle_t               bundle_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [u8sd_pkg::CpWidth-1:0]    code_point_o,
  output logic                            replaced_o,
  output logic                            last_of_run_o,
  output logic                            final_of_string_o
);
  import u8sd_pkg::*;

  res_t [MaxResults-1:0] ent_q, ent_d;
  logic [1:0]            rem_q, rem_d;
  logic                  eos_q, eos_d;
  logic                  load;
  logic                  pop;

  assign out_valid_o       = rem_q != 2'd0;
  assign pop               = out_valid_o && out_ready_i;
  assign load              = accept_i && (bundle_i.cnt != 2'd0);
  // A new request may enter while the last result of the previous one leaves.
  assign in_ready_o        = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_ready_i);
  assign code_point_o      = ent_q[0].cp;
  assign replaced_o        = ent_q[0].repl;
  assign last_of_run_o     = rem_q == 2'd1;
  assign final_of_string_o = (rem_q == 2'd1) && eos_q;

  always_comb begin
    rem_d = rem_q;
    ent_d = ent_q;
    eos_d = eos_q;
    if (load) begin
      rem_d = bundle_i.cnt;
      ent_d = bundle_i.ent;
      eos_d = bundle_i.eos;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
      ent_d = {res_t'('0), ent_q[2:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    eos_q <= eos_d;
  end

  `U8SD_ASSERT_NEXT(a_load_count, load, rem_q == $past(bundle_i.cnt), "result count not loaded")
  `U8SD_ASSERT_NEXT(a_pop_count, pop && !load, rem_q == $past(rem_q) - 2'd1, "result count not decremented")
  `U8SD_ASSERT(a_no_overrun, accept_i |-> rem_q == 2'd0 || (rem_q == 2'd1 && pop), "request accepted over pending results")

endmodule

// File: rtl/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder: byte requests in, code point requests out.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------
//   input    | in_valid_i / in_ready_o    | data_byte_i, string_end_i
//   output   | out_valid_o / out_ready_i  | code_point_o, replaced_o, last_of_run_o,
//            |                            | final_of_string_o
//   config   | cfg_we_i (no wait)         | cfg_wdata_i (skip_bom)
//
// A byte is parsed in the cycle it is accepted; its results appear in the next cycle.
// One byte per cycle is taken while each gives at most one result and output is ready.
// A cut sequence at a string end gives two or three results, sent one per cycle from
// the result register while output is ready; input waits for the last one to leave.
// Reset clears the pending count, marks a string start and clears skip_bom.
// A stalled output holds the result register; input then waits after the last result.

module utf8_stream_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  u8sd_pkg::byte_t               data_byte_i,
  input  logic                          string_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [u8sd_pkg::CpWidth-1:0]  code_point_o,
  output logic                          replaced_o,
  output logic                          last_of_run_o,
  output logic                          final_of_string_o
);
  import u8sd_pkg::*;

  logic    skip_bom_q;
  logic    accept;
  bundle_t bundle;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_bom_q <= 1'b0;
    end else if (cfg_we_i) begin
      skip_bom_q <= cfg_wdata_i;
    end
  end

  u8sd_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .string_end_i (string_end_i),
    .skip_bom_i   (skip_bom_q),
    .bundle_o     (bundle)
  );

  u8sd_burst u_burst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .bundle_i          (bundle),
    .in_ready_o        (in_ready_o),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .code_point_o      (code_point_o),
    .replaced_o        (replaced_o),
    .last_of_run_o     (last_of_run_o),
    .final_of_string_o (final_of_string_o)
  );

endmodule
